// ===== hw/rtl/kpc_pkg.sv =====
`default_nettype none
package kpc_pkg;

  localparam int unsigned NumKeys  = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned CfgAddrW = 2;

  // first key index that repeats while held
  localparam int unsigned HoldFirstKey = 2;

  localparam logic [CfgW-1:0] LockoutReset   = 16'd50;
  localparam logic [CfgW-1:0] LongPressReset = 16'd500;
  localparam logic [CfgW-1:0] RepeatReset    = 16'd200;

  typedef enum logic [CfgAddrW-1:0] {
    REG_LOCKOUT    = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_REPEAT     = 2'd2
  } kpc_reg_t;

  localparam logic [CodeW-1:0] EV_NONE       = 4'd0;
  localparam int unsigned      EvShortBase   = 1;
  localparam int unsigned      EvLongBase    = 5;
  localparam int unsigned      EvHoldBase    = 7;
  localparam int unsigned      EvReleaseBase = 9;

  typedef struct packed {
    logic [CfgW-1:0] lockout_ms;
    logic [CfgW-1:0] hold_thresh;
    logic [CfgW-1:0] rpt_gap;
  } kpc_cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kpc_scan_if.sv =====
`default_nettype none
interface kpc_scan_if;
  logic        valid;
  logic        ready;
  logic [3:0]  key_levels;
  logic [31:0] now_ms;

  modport source (output valid, output key_levels, output now_ms, input ready);
  modport sink   (input valid, input key_levels, input now_ms, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kpc_event_if.sv =====
`default_nettype none
interface kpc_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kpc_lane.sv =====
`default_nettype none
module kpc_lane #(
  parameter int unsigned KEY_IDX = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire kpc_pkg::kpc_cfg_t          cfg,
  input  wire logic                       accept,
  input  wire logic                       level,
  input  wire logic [kpc_pkg::TimeW-1:0]  now_ms,
  output logic      [kpc_pkg::CodeW-1:0]  lane_code
);
  import kpc_pkg::*;

  localparam bit HoldKey = (KEY_IDX >= HoldFirstKey);
  localparam logic [CodeW-1:0] EvShort = CodeW'(EvShortBase + KEY_IDX);
  localparam logic [CodeW-1:0] EvLong  = HoldKey ? EV_NONE : CodeW'(EvLongBase + KEY_IDX);
  localparam logic [CodeW-1:0] EvHold  =
    HoldKey ? CodeW'(EvHoldBase + KEY_IDX - HoldFirstKey) : EV_NONE;
  localparam logic [CodeW-1:0] EvRelease =
    HoldKey ? CodeW'(EvReleaseBase + KEY_IDX - HoldFirstKey) : EV_NONE;

  logic             key_down, key_down_next;
  logic             long_done, long_done_next;
  logic             hold_on, hold_on_next;
  logic [TimeW-1:0] press_start, press_start_next;
  logic [TimeW-1:0] rpt_stamp, rpt_stamp_next;

  logic             down_now;
  logic [TimeW-1:0] held;
  logic [TimeW-1:0] since_repeat;
  logic [TimeW-1:0] lockout_w, long_w, repeat_w;

  assign down_now     = ~level;
  assign held         = now_ms - press_start;
  assign since_repeat = now_ms - rpt_stamp;
  assign lockout_w    = TimeW'(cfg.lockout_ms);
  assign long_w       = TimeW'(cfg.hold_thresh);
  assign repeat_w     = TimeW'(cfg.rpt_gap);

  always_comb begin
    key_down_next    = key_down;
    long_done_next   = long_done;
    hold_on_next     = hold_on;
    press_start_next = press_start;
    rpt_stamp_next   = rpt_stamp;
    lane_code        = EV_NONE;
    if (down_now && !key_down) begin
      if (held > lockout_w) begin
        key_down_next    = 1'b1;
        press_start_next = now_ms;
        long_done_next   = 1'b0;
        hold_on_next     = 1'b0;
      end
    end else if (!down_now && key_down) begin
      key_down_next = 1'b0;
      if (hold_on) begin
        lane_code = EvRelease;
      end else if (!long_done && held < long_w) begin
        lane_code = EvShort;
      end
      hold_on_next   = 1'b0;
      long_done_next = 1'b0;
    end else if (down_now && key_down) begin
      if (!long_done && held >= long_w) begin
        long_done_next = 1'b1;
        if (HoldKey) begin
          hold_on_next = 1'b1;
          lane_code    = EvHold;
        end else begin
          lane_code = EvLong;
        end
      end
      // repeat test sees the hold flag as just updated
      if (hold_on_next && held > long_w && since_repeat > repeat_w) begin
        rpt_stamp_next = now_ms;
        lane_code      = EvHold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down    <= 1'b0;
      long_done   <= 1'b0;
      hold_on     <= 1'b0;
      press_start <= '0;
      rpt_stamp   <= '0;
    end else if (accept) begin
      key_down    <= key_down_next;
      long_done   <= long_done_next;
      hold_on     <= hold_on_next;
      press_start <= press_start_next;
      rpt_stamp   <= rpt_stamp_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/kpc_merge.sv =====
`default_nettype none
module kpc_merge (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [kpc_pkg::CodeW-1:0] lane_code [kpc_pkg::NumKeys],
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [kpc_pkg::CodeW-1:0] out_code
);
  import kpc_pkg::*;

  logic [CodeW-1:0] win_code;

  // higher-numbered key wins
  always_comb begin
    win_code = EV_NONE;
    for (int i = 0; i < NumKeys; i++) begin
      if (lane_code[i] != EV_NONE) begin
        win_code = lane_code[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_code <= win_code;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/keypad_press_classifier_core.sv =====
`default_nettype none
// The event word for a scan is valid on the cycle after the scan is taken.
// One scan per clock unless output stalls; four key lanes update side by side and a
// priority merge feeds a single output register, which stalls input only when full.
// Reset (rst, synchronous): clears every key's state and output valid, and loads
// lockout 50, long press 500, repeat 200.
module keypad_press_classifier_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [kpc_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [kpc_pkg::CfgW-1:0]     cfg_data,
  kpc_scan_if.sink                          scan,
  kpc_event_if.source                       evt
);
  import kpc_pkg::*;

  kpc_cfg_t         cfg;
  logic             accept;
  logic [CodeW-1:0] lane_code [NumKeys];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_ms  <= LockoutReset;
      cfg.hold_thresh <= LongPressReset;
      cfg.rpt_gap     <= RepeatReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOCKOUT:    cfg.lockout_ms  <= cfg_data;
        REG_LONG_PRESS: cfg.hold_thresh <= cfg_data;
        REG_REPEAT:     cfg.rpt_gap     <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a scan whenever the output register is empty or being drained
  assign scan.ready = ~evt.valid | evt.ready;
  assign accept     = scan.valid & scan.ready;

  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    kpc_lane #(.KEY_IDX(k)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .accept    (accept),
      .level     (scan.key_levels[k]),
      .now_ms    (scan.now_ms),
      .lane_code (lane_code[k])
    );
  end

  kpc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .lane_code (lane_code),
    .out_valid (evt.valid),
    .out_ready (evt.ready),
    .out_code  (evt.event_code)
  );
endmodule
`default_nettype wire
